// ----- sv/swt_pkg.sv -----
// Package for the software timer table: field widths, operation kinds
// and report limits shared by the table's RTL files. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package swt_pkg;

  localparam int KIND_W      = 3;
  localparam int HANDLE_W    = 4;
  localparam int TIME_W      = 32;
  localparam int HANDLE_MAX  = 15;
  localparam int MAX_REPORTS = 8;
  localparam int CNT_W       = 4;
  localparam int IN_DATA_W   = 72;
  localparam int OUT_DATA_W  = 8;

  typedef logic [KIND_W-1:0]   kind_t;
  typedef logic [HANDLE_W-1:0] handle_t;
  typedef logic [TIME_W-1:0]   tick_t;

  localparam kind_t KIND_CREATE     = 3'd0;
  localparam kind_t KIND_SET_PERIOD = 3'd1;
  localparam kind_t KIND_RELOAD     = 3'd2;
  localparam kind_t KIND_DELETE     = 3'd3;
  localparam kind_t KIND_TICK       = 3'd4;

endpackage

`default_nettype wire

// ----- sv/swt_ram.sv -----
// Simple dual-port synchronous RAM with registered read data and read enable.
// Holds per-slot period or expiry words for the timer table. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module swt_ram #(
  parameter int DEPTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  parameter int W     = 32
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ----- sv/software_timer_table_top.sv -----
// Software timer table top level: command decode, slot scan and output register.
// Depends on swt_pkg and swt_ram (period and expiry memories).
//
// Usage:
//   in_*  : one command per transfer; in_tuser carries the kind (create,
//           set period, reload, delete, tick), in_tdata the operands.
//   out_* : result transfers; out_tlast marks the final result of a command.
//   in_tready is high only while the block is idle; one command at a time.
// Sequencing:
//   Create, set period, reload, delete: result loaded once the output
//   register is free, then the block returns to idle for the next command.
//   Tick: the scan reads one slot a cycle from the period/expiry memory
//   port while it is not held by a stall; up to 8 expiries are reported,
//   in slot order.
// Reset: all slots free and inactive; no clearing pass, memories are
//   written by create before use.
// Stall: results wait in the output register; a scan holds on the next
//   expiry while the previous report has not been taken.
`timescale 1ns / 1ps
`default_nettype none

module software_timer_table_top #(
  parameter int NUM_TIMERS = 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // handle[3:0], period[35:4], auto_reload[36], start_active[37], now[69:38]
  input  logic [swt_pkg::IN_DATA_W-1:0]    in_tdata,
  // kind[2:0]
  input  logic [swt_pkg::KIND_W-1:0]       in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // result_handle[3:0], expired[4]
  output logic [swt_pkg::OUT_DATA_W-1:0]   out_tdata,
  output logic                             out_tlast
);

  import swt_pkg::*;

  localparam int LIM   = (NUM_TIMERS > HANDLE_MAX) ? HANDLE_MAX : NUM_TIMERS;
  localparam int IDX_W = (LIM > 1) ? $clog2(LIM) : 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_OP   = 3'd1;
  localparam logic [2:0] S_RLD  = 3'd2;
  localparam logic [2:0] S_SCAN = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0]       state_r, state_nxt;
  kind_t            kind_r, kind_nxt;
  handle_t          h_r, h_nxt;
  tick_t            per_r, per_nxt;
  logic             rep_r, rep_nxt;
  logic             start_r, start_nxt;
  tick_t            now_r, now_nxt;
  logic [IDX_W-1:0] c_r, c_nxt;
  logic [CNT_W-1:0] n_r, n_nxt;
  logic             pend_r, pend_nxt;
  handle_t          pend_h_r, pend_h_nxt;
  logic             out_valid_r, out_valid_nxt;
  handle_t          out_h_r, out_h_nxt;
  logic             out_exp_r, out_exp_nxt;
  logic             out_last_r, out_last_nxt;
  logic [LIM-1:0]   used_r, used_nxt;
  logic [LIM-1:0]   active_r, active_nxt;
  logic [LIM-1:0]   repeat_r, repeat_nxt;

  logic             in_acc;
  handle_t          in_h;
  logic             in_valid_h;
  logic             valid_h;
  logic [IDX_W-1:0] idx;
  logic             free_found;
  logic [IDX_W-1:0] free_idx;
  logic             out_free;
  logic             hit;
  logic             last_slot;

  logic             per_we, exp_we, rd_en;
  logic [IDX_W-1:0] per_wa, exp_wa, rd_addr;
  tick_t            per_wd, exp_wd, per_rd, exp_rd;

  swt_ram #(.DEPTH(LIM), .AW(IDX_W), .W(TIME_W)) u_per_ram (
    .clk   (clk),
    .we    (per_we),
    .waddr (per_wa),
    .wdata (per_wd),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (per_rd)
  );

  swt_ram #(.DEPTH(LIM), .AW(IDX_W), .W(TIME_W)) u_exp_ram (
    .clk   (clk),
    .we    (exp_we),
    .waddr (exp_wa),
    .wdata (exp_wd),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (exp_rd)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid & in_tready;
  assign in_h       = in_tdata[3:0];
  assign in_valid_h = (in_h != '0) && (in_h <= HANDLE_W'(LIM));
  assign valid_h    = (h_r != '0) && (h_r <= HANDLE_W'(LIM));
  assign idx        = valid_h ? IDX_W'(h_r - HANDLE_W'(1)) : '0;
  assign out_free   = ~out_valid_r | out_tready;
  assign hit        = used_r[c_r] & active_r[c_r] & (now_r >= exp_rd) &
                      (n_r < CNT_W'(MAX_REPORTS));
  assign last_slot  = (c_r == IDX_W'(LIM - 1));

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = LIM - 1; i >= 0; i--) begin
      if (!used_r[i]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
  end

  always_comb begin
    logic    emit;
    handle_t emit_h;
    logic    emit_exp;
    logic    emit_last;

    state_nxt  = state_r;
    kind_nxt   = kind_r;
    h_nxt      = h_r;
    per_nxt    = per_r;
    rep_nxt    = rep_r;
    start_nxt  = start_r;
    now_nxt    = now_r;
    c_nxt      = c_r;
    n_nxt      = n_r;
    pend_nxt   = pend_r;
    pend_h_nxt = pend_h_r;
    used_nxt   = used_r;
    active_nxt = active_r;
    repeat_nxt = repeat_r;
    per_we     = 1'b0;
    per_wa     = '0;
    per_wd     = per_r;
    exp_we     = 1'b0;
    exp_wa     = '0;
    exp_wd     = '0;
    rd_en      = 1'b0;
    rd_addr    = '0;
    emit       = 1'b0;
    emit_h     = h_r;
    emit_exp   = 1'b0;
    emit_last  = 1'b1;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          kind_nxt  = in_tuser;
          h_nxt     = in_h;
          per_nxt   = in_tdata[35:4];
          rep_nxt   = in_tdata[36];
          start_nxt = in_tdata[37];
          now_nxt   = in_tdata[69:38];
          unique case (in_tuser)
            KIND_RELOAD: begin
              rd_en     = 1'b1;
              rd_addr   = in_valid_h ? IDX_W'(in_h - HANDLE_W'(1)) : '0;
              state_nxt = S_RLD;
            end
            KIND_TICK: begin
              rd_en     = 1'b1;
              rd_addr   = '0;
              c_nxt     = '0;
              n_nxt     = '0;
              pend_nxt  = 1'b0;
              state_nxt = S_SCAN;
            end
            default: begin
              state_nxt = S_OP;
            end
          endcase
        end
      end
      S_OP: begin
        if (out_free) begin
          emit = 1'b1;
          case (kind_r)
            KIND_CREATE: begin
              emit_h = '0;
              if (free_found) begin
                used_nxt[free_idx]   = 1'b1;
                active_nxt[free_idx] = start_r;
                repeat_nxt[free_idx] = rep_r;
                per_we = 1'b1;
                per_wa = free_idx;
                exp_we = 1'b1;
                exp_wa = free_idx;
                exp_wd = now_r + per_r;
                emit_h = HANDLE_W'(free_idx) + HANDLE_W'(1);
              end
            end
            KIND_SET_PERIOD: begin
              if (valid_h) begin
                per_we = 1'b1;
                per_wa = idx;
              end
            end
            KIND_DELETE: begin
              if (valid_h) begin
                used_nxt[idx]   = 1'b0;
                active_nxt[idx] = 1'b0;
              end
            end
            default: begin
            end
          endcase
          state_nxt = S_IDLE;
        end
      end
      S_RLD: begin
        if (out_free) begin
          emit = 1'b1;
          if (valid_h) begin
            exp_we          = 1'b1;
            exp_wa          = idx;
            exp_wd          = now_r + per_rd;
            active_nxt[idx] = 1'b1;
          end
          state_nxt = S_IDLE;
        end
      end
      S_SCAN: begin
        if (!(hit && pend_r && !out_free)) begin
          if (hit) begin
            if (repeat_r[c_r]) begin
              exp_we = 1'b1;
              exp_wa = c_r;
              exp_wd = now_r + per_rd;
            end else begin
              active_nxt[c_r] = 1'b0;
            end
            if (pend_r) begin
              emit      = 1'b1;
              emit_h    = pend_h_r;
              emit_exp  = 1'b1;
              emit_last = 1'b0;
            end
            pend_nxt   = 1'b1;
            pend_h_nxt = HANDLE_W'(c_r) + HANDLE_W'(1);
            n_nxt      = n_r + CNT_W'(1);
          end
          if (last_slot) begin
            state_nxt = S_FIN;
          end else begin
            c_nxt   = IDX_W'(c_r + IDX_W'(1));
            rd_en   = 1'b1;
            rd_addr = IDX_W'(c_r + IDX_W'(1));
          end
        end
      end
      S_FIN: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_h    = pend_r ? pend_h_r : '0;
          emit_exp  = pend_r;
          emit_last = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    out_valid_nxt = out_valid_r;
    out_h_nxt     = out_h_r;
    out_exp_nxt   = out_exp_r;
    out_last_nxt  = out_last_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_h_nxt     = emit_h;
      out_exp_nxt   = emit_exp;
      out_last_nxt  = emit_last;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pend_r      <= 1'b0;
      n_r         <= '0;
      c_r         <= '0;
      out_valid_r <= 1'b0;
      used_r      <= '0;
      active_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      n_r         <= n_nxt;
      c_r         <= c_nxt;
      out_valid_r <= out_valid_nxt;
      used_r      <= used_nxt;
      active_r    <= active_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r     <= kind_nxt;
    h_r        <= h_nxt;
    per_r      <= per_nxt;
    rep_r      <= rep_nxt;
    start_r    <= start_nxt;
    now_r      <= now_nxt;
    pend_h_r   <= pend_h_nxt;
    out_h_r    <= out_h_nxt;
    out_exp_r  <= out_exp_nxt;
    out_last_r <= out_last_nxt;
    repeat_r   <= repeat_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W - HANDLE_W - 1){1'b0}}, out_exp_r, out_h_r};
  assign out_tlast  = out_last_r;

`ifndef ASSERT_OFF
  a_report_limit: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= CNT_W'(MAX_REPORTS))
    else $error("tick report count above limit");

  a_expiry_handle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_exp_r |-> out_h_r != '0)
    else $error("expiry reported with null handle");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("command accepted while busy");
`endif

endmodule

`default_nettype wire

// ----- dv/tb.sv -----
// Testbench for software_timer_table_top: drives create, set-period, reload, delete,
// tick and spare-kind commands, predicts every timer report and checks each transfer.
// Depends on swt_pkg and the software_timer_table_top RTL.
`timescale 1ns / 1ps

module tb;
  import swt_pkg::*;

  localparam int NUM_TIMERS   = 8;
  localparam int USABLE       = (NUM_TIMERS > HANDLE_MAX) ? HANDLE_MAX : NUM_TIMERS;
  localparam int RANDOM_ITEMS = 230;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 40;

  localparam kind_t KIND_SPARE_FIRST = 3'd5;
  localparam kind_t KIND_SPARE_LAST  = 3'd7;

  typedef struct packed {
    handle_t handle;
    logic    expired;
    logic    last;
  } report_t;

  class timer_table_scoreboard;
    logic    used [NUM_TIMERS];
    logic    active [NUM_TIMERS];
    logic    periodic [NUM_TIMERS];
    tick_t   period [NUM_TIMERS];
    tick_t   expiry [NUM_TIMERS];
    bit      period_known [NUM_TIMERS];
    report_t awaited_reports[$];
    int      mismatches;

    function new();
      for (int i = 0; i < NUM_TIMERS; i++) begin
        used[i] = 1'b0;
        active[i] = 1'b0;
        periodic[i] = 1'b0;
        period[i] = '0;
        expiry[i] = '0;
        period_known[i] = 1'b0;
      end
      mismatches = 0;
    endfunction

    function void note_command(kind_t kind, handle_t h, tick_t per, logic rep, logic start,
                               tick_t now);
      bit      valid;
      int      idx;
      handle_t got;
      report_t fired[$];
      valid = (h != 0) && (h <= USABLE);
      idx = valid ? h - 1 : 0;
      case (kind)
        KIND_CREATE: begin
          got = '0;
          for (int i = 0; i < USABLE; i++) begin
            if (!used[i]) begin
              used[i] = 1'b1;
              period[i] = per;
              period_known[i] = 1'b1;
              periodic[i] = rep;
              active[i] = start;
              if (start) expiry[i] = now + per;
              got = handle_t'(i + 1);
              break;
            end
          end
          awaited_reports.push_back('{got, 1'b0, 1'b1});
        end
        KIND_SET_PERIOD: begin
          if (valid) begin
            period[idx] = per;
            period_known[idx] = 1'b1;
          end
          awaited_reports.push_back('{h, 1'b0, 1'b1});
        end
        KIND_RELOAD: begin
          if (valid) begin
            expiry[idx] = now + period[idx];
            active[idx] = 1'b1;
          end
          awaited_reports.push_back('{h, 1'b0, 1'b1});
        end
        KIND_DELETE: begin
          if (valid) begin
            used[idx] = 1'b0;
            active[idx] = 1'b0;
          end
          awaited_reports.push_back('{h, 1'b0, 1'b1});
        end
        KIND_TICK: begin
          for (int i = 0; i < USABLE && fired.size() < MAX_REPORTS; i++) begin
            if (used[i] && active[i] && now >= expiry[i]) begin
              if (periodic[i]) expiry[i] = now + period[i];
              else active[i] = 1'b0;
              fired.push_back('{handle_t'(i + 1), 1'b1, 1'b0});
            end
          end
          if (fired.size() == 0) begin
            awaited_reports.push_back('{handle_t'(0), 1'b0, 1'b1});
          end else begin
            fired[fired.size() - 1].last = 1'b1;
            foreach (fired[i]) awaited_reports.push_back(fired[i]);
          end
        end
        default: awaited_reports.push_back('{h, 1'b0, 1'b1});
      endcase
    endfunction

    function void check_report(handle_t h, logic expired, logic last);
      report_t want;
      if (awaited_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result handle %0d expired %0b last %0b",
                   $time, h, expired, last);
        return;
      end
      want = awaited_reports.pop_front();
      if (h !== want.handle || expired !== want.expired || last !== want.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: mismatch: expected handle %0d expired %0b last %0b, got handle %0d expired %0b last %0b",
                   $time, want.handle, want.expired, want.last, h, expired, last);
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [KIND_W-1:0]     in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;

  timer_table_scoreboard timers = new();
  int    idle_pct;
  int    cycle_count;
  tick_t clock_now;

  software_timer_table_top #(
    .NUM_TIMERS(NUM_TIMERS)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      timers.check_report(out_tdata[HANDLE_W-1:0], out_tdata[HANDLE_W], out_tlast);
    out_tready <= ($urandom_range(0, 99) >= idle_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("software_timer_table_top test failed");
      $finish;
    end
  end

  task automatic send_command(kind_t kind, handle_t h, tick_t per, logic rep, logic start,
                              tick_t now);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {2'b00, now, start, rep, per, h};
    do @(posedge clk); while (!in_tready);
    timers.note_command(kind, h, per, rep, start, now);
  endtask

  // hold the sender until every predicted report has been taken
  task automatic wait_for_reports();
    in_tvalid <= 1'b0;
    while (timers.awaited_reports.size() != 0) @(posedge clk);
  endtask

  function automatic tick_t pick_period();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return tick_t'($urandom());
      2:       return '1;
      default: return tick_t'($urandom_range(1, 12));
    endcase
  endfunction

  function automatic handle_t pick_handle();
    if ($urandom_range(0, 9) == 0) return handle_t'($urandom_range(0, 15));
    return handle_t'($urandom_range(1, USABLE));
  endfunction

  initial begin
    kind_t   kind;
    handle_t h;
    tick_t   per;
    tick_t   now;
    int      sel;
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    in_tuser    <= '0;
    out_tready  <= 1'b0;
    idle_pct    = 10;
    cycle_count = 0;
    clock_now   = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    send_command(KIND_TICK, 4'd0, '0, 1'b0, 1'b0, '0);
    send_command(KIND_CREATE, 4'd0, '0, 1'b1, 1'b1, '0);
    send_command(KIND_CREATE, 4'd15, '1, 1'b0, 1'b1, 32'd1);
    send_command(KIND_CREATE, 4'd0, 32'd5, 1'b1, 1'b0, 32'd7);
    send_command(KIND_CREATE, 4'd0, 32'd3, 1'b0, 1'b1, '1);
    send_command(KIND_CREATE, 4'd0, 32'd10, 1'b1, 1'b1, 32'd100);
    send_command(KIND_CREATE, 4'd0, 32'd10, 1'b0, 1'b1, 32'd100);
    send_command(KIND_CREATE, 4'd0, 32'd20, 1'b1, 1'b1, 32'd100);
    send_command(KIND_CREATE, 4'd0, 32'd30, 1'b0, 1'b0, 32'd100);
    send_command(KIND_CREATE, 4'd0, 32'd9, 1'b1, 1'b1, 32'd100);
    send_command(KIND_TICK, 4'd0, '0, 1'b0, 1'b0, 32'd2);
    send_command(KIND_SET_PERIOD, 4'd0, 32'd4, 1'b0, 1'b0, '0);
    send_command(KIND_SET_PERIOD, 4'd9, 32'd4, 1'b0, 1'b0, '0);
    send_command(KIND_RELOAD, 4'd15, '0, 1'b0, 1'b0, 32'd50);
    send_command(KIND_DELETE, 4'd0, '0, 1'b0, 1'b0, '0);
    send_command(KIND_SPARE_FIRST, 4'd15, '1, 1'b1, 1'b1, '1);
    send_command(kind_t'(6), 4'd3, 32'd1, 1'b0, 1'b1, 32'd3);
    send_command(KIND_SPARE_LAST, 4'd1, '0, 1'b1, 1'b0, '0);
    send_command(KIND_RELOAD, 4'd3, '0, 1'b0, 1'b0, 32'd10);
    send_command(KIND_SET_PERIOD, 4'd3, 32'd1, 1'b0, 1'b0, '0);
    send_command(KIND_DELETE, 4'd5, '0, 1'b0, 1'b0, '0);
    send_command(KIND_RELOAD, 4'd5, '0, 1'b0, 1'b0, '0);
    send_command(KIND_TICK, 4'd0, '0, 1'b0, 1'b0, '1);
    send_command(KIND_DELETE, 4'd1, '0, 1'b0, 1'b0, '0);
    send_command(KIND_TICK, 4'd8, '1, 1'b1, 1'b1, '0);
    wait_for_reports();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      idle_pct = (n >= 100 && n < 160) ? 0 : 10;
      if (n % 75 == 74) wait_for_reports();
      if ($urandom_range(0, 49) == 0) clock_now = tick_t'($urandom());
      sel = $urandom_range(0, 99);
      if (sel < 40)      kind = KIND_TICK;
      else if (sel < 60) kind = KIND_CREATE;
      else if (sel < 70) kind = KIND_SET_PERIOD;
      else if (sel < 82) kind = KIND_RELOAD;
      else if (sel < 97) kind = KIND_DELETE;
      else kind = kind_t'($urandom_range(KIND_SPARE_FIRST, KIND_SPARE_LAST));
      h   = pick_handle();
      per = pick_period();
      now = clock_now;
      if (kind == KIND_TICK) begin
        if ($urandom_range(0, 19) == 0) now = tick_t'($urandom());
        clock_now = clock_now + tick_t'($urandom_range(0, 6));
      end
      // a slot whose period was never written must not be reloaded
      if (kind == KIND_RELOAD && h != 0 && h <= USABLE && !timers.period_known[h - 1])
        kind = KIND_SET_PERIOD;
      send_command(kind, h, per, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 3) != 0),
                   now);
    end

    wait_for_reports();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (timers.mismatches == 0 && timers.awaited_reports.size() == 0) begin
      $display("software_timer_table_top test passed");
    end else begin
      $display("software_timer_table_top test failed");
    end
    $finish;
  end

endmodule
